@@ sv/hfr_pkg.sv @@
// Shared types and constants for the HTTP response body framer.
// Depends on nothing; every other file of the block but hfr_if imports it.
package hfr_pkg;

	localparam int unsigned LENGTH_BITS_DEF = 32;
	localparam logic [31:0] MAX_BYTES_RST = 32'(8 << 20);

	// Operation codes carried in the func field.
	localparam logic [1:0] FUNC_BYTE   = 2'd0;
	localparam logic [1:0] FUNC_CLOSE  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;
	// The remaining code is not assigned and is ignored by the framer.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// Error codes reported with a finished result.
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_NOT_HTTP  = 3'd1;
	localparam logic [2:0] ERR_MID_LINE  = 3'd2;
	localparam logic [2:0] ERR_TRUNCATED = 3'd3;
	localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

	// Tokens, first character in the most significant byte.
	localparam logic [4:0][7:0]  TOK_HTTP    = "HTTP/";
	localparam logic [16:0][7:0] TOK_TE      = "transfer-encoding";
	localparam logic [13:0][7:0] TOK_CL      = "content-length";
	localparam logic [6:0][7:0]  TOK_CHUNKED = "chunked";

	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] data_byte;
	} item_t;

endpackage

@@ sv/hfr_if.sv @@
// Valid/ready channel interfaces of the framer: input items, results and configuration.
// Depends on hfr_pkg for nothing but keeps the same house widths.
interface hfr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] data_byte;
	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface hfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       has_body;
	logic       finished;
	logic [2:0] error_code;
	modport source (output valid, output body_byte, output has_body, output finished,
		output error_code, input ready);
	modport sink (input valid, input body_byte, input has_body, input finished,
		input error_code, output ready);
endinterface

interface hfr_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ sv/hfr_in_reg.sv @@
// Input register of the framer: holds one accepted item until the step stage takes it.
// Depends on hfr_pkg (item_t) and the input channel interface.
module hfr_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	hfr_in_if.sink        in_ch,
	input  logic          adv,
	output logic          valid_s1,
	output hfr_pkg::item_t item_s1
);
	import hfr_pkg::*;

	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1.func <= in_ch.func;
			item_s1.data_byte <= in_ch.data_byte;
		end
	end

endmodule

@@ sv/hfr_step.sv @@
// Parser state, limit register and result register of the framer.
// Depends on hfr_pkg and the result and configuration channel interfaces.
module hfr_step #(
	parameter int unsigned LENGTH_BITS = hfr_pkg::LENGTH_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s1,
	input  hfr_pkg::item_t item_s1,
	output logic           adv,
	hfr_out_if.source      out_ch,
	hfr_cfg_if.sink        cfg_ch
);
	import hfr_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MASK = '1;

	typedef enum logic [3:0] {
		PH_STATUS, PH_H_LEAD, PH_H_NAME, PH_H_TRAIL, PH_H_VALUE,
		PH_C_SIZE, PH_C_DATA, PH_C_TAIL, PH_B_LEN, PH_B_CLOSE, PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic                   cr;
		logic [4:0]             lpos;
		logic [1:0]             nc;
		logic [2:0]             tmi;
		logic [2:0]             nss;
		logic                   chunked;
		logic                   lenf;
		logic [LENGTH_BITS-1:0] decl;
		logic [LENGTH_BITS-1:0] rem;
		logic [31:0]            rcv;
		logic [4:0]             nidx;
		logic                   neg;
	} st_t;

	typedef struct packed {
		logic [2:0]             nss;
		logic                   neg;
		logic [LENGTH_BITS-1:0] acc;
	} scan_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] body_byte;
		logic       has_body;
		logic       finished;
		logic [2:0] error_code;
	} res_t;

	st_t         st_q, nx;
	res_t        res;
	logic [31:0] max_q;

	function automatic st_t clear_st();
		st_t s;
		s = '0;
		s.phase = PH_STATUS;
		s.nc = 2'b11;
		return s;
	endfunction

	function automatic st_t reset_line(st_t s);
		st_t n;
		n = s;
		n.lpos = '0;
		n.nidx = '0;
		n.nc = 2'b11;
		n.tmi = '0;
		n.nss = '0;
		n.neg = 1'b0;
		return n;
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == " ") || (c == 8'h09);
	endfunction

	function automatic logic [7:0] lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	// One character of a decimal or hex number, saturating at all ones.
	function automatic scan_t scan_char(scan_t s, logic [7:0] c, logic hex);
		scan_t                  n;
		logic [4:0]             d;
		logic [4:0]             base;
		logic                   go;
		logic [LENGTH_BITS+4:0] wide;
		n = s;
		go = 1'b1;
		base = hex ? 5'd16 : 5'd10;
		d = 5'd16;
		wide = '0;
		if (c >= "0" && c <= "9") d = 5'(c - "0");
		else if (hex && c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
		else if (hex && c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
		if (n.nss == 3'd0) begin
			if (is_blank(c) || (c >= 8'd10 && c <= 8'd13)) begin
				go = 1'b0;
			end else if (c == "+" || c == "-") begin
				if (c == "-") n.neg = 1'b1;
				n.nss = 3'd1;
				go = 1'b0;
			end else begin
				n.nss = 3'd1;
			end
		end
		if (go) begin
			if (n.nss == 3'd1) begin
				if (hex && c == "0") begin
					n.nss = 3'd2;
					go = 1'b0;
				end else begin
					n.nss = (d < base) ? 3'd3 : 3'd4;
				end
			end else if (n.nss == 3'd2) begin
				if (c == "x" || c == "X") begin
					n.nss = 3'd3;
					go = 1'b0;
				end else begin
					n.nss = (d < base) ? 3'd3 : 3'd4;
				end
			end else if (n.nss == 3'd3) begin
				if (d >= base) n.nss = 3'd4;
			end else begin
				go = 1'b0;
			end
		end
		if (go && n.nss == 3'd3 && d < base) begin
			if (hex) wide = {1'b0, n.acc, 4'b0} + (LENGTH_BITS+5)'(d);
			else wide = {2'b0, n.acc, 3'b0} + {4'b0, n.acc, 1'b0} + (LENGTH_BITS+5)'(d);
			n.acc = (wide > (LENGTH_BITS+5)'(LEN_MASK)) ? LEN_MASK : wide[LENGTH_BITS-1:0];
		end
		return n;
	endfunction

	function automatic logic te_hit(logic [4:0] i, logic [7:0] lc);
		return (i < 5'd17) && (lc == TOK_TE[5'd16 - i]);
	endfunction

	function automatic logic cl_hit(logic [4:0] i, logic [7:0] lc);
		return (i < 5'd14) && (lc == TOK_CL[5'd13 - i]);
	endfunction

	function automatic st_t name_feed(st_t s, logic [7:0] lc);
		st_t n;
		n = s;
		if (n.nc[0] && !te_hit(n.nidx, lc)) n.nc[0] = 1'b0;
		if (n.nc[1] && !cl_hit(n.nidx, lc)) n.nc[1] = 1'b0;
		if (n.nidx < 5'd31) n.nidx = n.nidx + 5'd1;
		return n;
	endfunction

	function automatic st_t open_value(st_t s, logic named);
		st_t        n;
		logic [1:0] kind;
		n = s;
		kind = 2'd0;
		if (named && n.nc[0] && n.nidx == 5'd17) kind = 2'd1;
		else if (named && n.nc[1] && n.nidx == 5'd14) kind = 2'd2;
		n.nc = kind;
		n.phase = PH_H_VALUE;
		if (kind == 2'd1) begin
			n.chunked = 1'b0;
			n.tmi = '0;
		end
		if (kind == 2'd2) begin
			n.lenf = 1'b1;
			n.decl = '0;
			n.nss = '0;
			n.neg = 1'b0;
		end
		return n;
	endfunction

	function automatic st_t line_char(st_t s, logic [7:0] c);
		st_t        n;
		scan_t      sc;
		logic [7:0] lc;
		n = s;
		lc = lower(c);
		sc = '0;
		if (n.lpos < 5'd31) n.lpos = n.lpos + 5'd1;
		case (n.phase)
			PH_STATUS: begin
				if (n.tmi < 3'd5)
					n.tmi = (c == TOK_HTTP[3'd4 - n.tmi]) ? n.tmi + 3'd1 : 3'd6;
			end
			PH_H_LEAD: begin
				if (c == ":") n = open_value(n, 1'b0);
				else if (!is_blank(c)) begin
					n = name_feed(n, lc);
					n.phase = PH_H_NAME;
				end
			end
			PH_H_NAME: begin
				if (c == ":") n = open_value(n, 1'b1);
				else if (is_blank(c)) n.phase = PH_H_TRAIL;
				else n = name_feed(n, lc);
			end
			PH_H_TRAIL: begin
				if (c == ":") n = open_value(n, 1'b1);
				else if (!is_blank(c)) begin
					n.nc = 2'd0;
					n = name_feed(n, lc);
					n.phase = PH_H_NAME;
				end
			end
			PH_H_VALUE: begin
				if (n.nc == 2'd1 && n.tmi < 3'd7) begin
					if (lc == TOK_CHUNKED[3'd6 - n.tmi]) n.tmi = n.tmi + 3'd1;
					else n.tmi = (lc == "c") ? 3'd1 : 3'd0;
					if (n.tmi == 3'd7) n.chunked = 1'b1;
				end else if (n.nc == 2'd2) begin
					sc = scan_char('{nss: n.nss, neg: n.neg, acc: n.decl}, c, 1'b0);
					n.nss = sc.nss;
					n.neg = sc.neg;
					n.decl = sc.acc;
				end
			end
			PH_C_SIZE: begin
				sc = scan_char('{nss: n.nss, neg: n.neg, acc: n.rem}, c, 1'b1);
				n.nss = sc.nss;
				n.neg = sc.neg;
				n.rem = sc.acc;
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	always_comb begin
		logic [7:0] b;
		nx = st_q;
		res = '0;
		b = item_s1.data_byte;
		if (item_s1.func == FUNC_CLEAR) begin
			nx = clear_st();
		end else if (item_s1.func == FUNC_CLOSE && st_q.phase != PH_DONE) begin
			nx.phase = PH_DONE;
			nx.cr = 1'b0;
			res.valid = 1'b1;
			res.finished = 1'b1;
			if (st_q.rcv > max_q) res.error_code = ERR_TOO_LARGE;
			else if (st_q.phase == PH_B_CLOSE) res.error_code = ERR_OK;
			else if (st_q.phase == PH_C_DATA || st_q.phase == PH_B_LEN)
				res.error_code = ERR_TRUNCATED;
			else res.error_code = ERR_MID_LINE;
		end else if (item_s1.func == FUNC_BYTE && st_q.phase != PH_DONE) begin
			if (st_q.rcv > max_q) begin
				nx.phase = PH_DONE;
				nx.cr = 1'b0;
				res.valid = 1'b1;
				res.finished = 1'b1;
				res.error_code = ERR_TOO_LARGE;
			end else begin
				if (st_q.rcv != '1) nx.rcv = st_q.rcv + 32'd1;
				case (st_q.phase)
					PH_C_DATA: begin
						nx.rem = st_q.rem - 1'b1;
						if (nx.rem == '0) begin
							nx = reset_line(nx);
							nx.phase = PH_C_TAIL;
						end
						res.valid = 1'b1;
						res.has_body = 1'b1;
						res.body_byte = b;
					end
					PH_B_LEN: begin
						nx.rem = st_q.rem - 1'b1;
						res.valid = 1'b1;
						res.has_body = 1'b1;
						res.body_byte = b;
						if (nx.rem == '0) begin
							nx.phase = PH_DONE;
							res.finished = 1'b1;
						end
					end
					PH_B_CLOSE: begin
						res.valid = 1'b1;
						res.has_body = 1'b1;
						res.body_byte = b;
					end
					default: begin
						if (st_q.cr && b == CH_LF) begin
							// End of a line: act on the phase it closes.
							nx.cr = 1'b0;
							case (st_q.phase)
								PH_STATUS: begin
									if (st_q.tmi != 3'd5) begin
										nx.phase = PH_DONE;
										res.valid = 1'b1;
										res.finished = 1'b1;
										res.error_code = ERR_NOT_HTTP;
									end else begin
										nx = reset_line(nx);
										nx.phase = PH_H_LEAD;
									end
								end
								PH_C_SIZE: begin
									if (st_q.neg && st_q.rem != '0) nx.rem = LEN_MASK;
									nx = reset_line(nx);
									if (nx.rem == '0) begin
										nx.phase = PH_DONE;
										res.valid = 1'b1;
										res.finished = 1'b1;
										res.error_code = ERR_OK;
									end else begin
										nx.phase = PH_C_DATA;
									end
								end
								PH_C_TAIL: begin
									nx = reset_line(nx);
									nx.rem = '0;
									nx.phase = PH_C_SIZE;
								end
								default: begin
									if (st_q.phase == PH_H_VALUE && st_q.nc == 2'd2 &&
										st_q.neg && st_q.decl != '0)
										nx.decl = LEN_MASK;
									nx = reset_line(nx);
									if (st_q.lpos != '0) begin
										nx.phase = PH_H_LEAD;
									end else if (st_q.chunked) begin
										nx.rem = '0;
										nx.phase = PH_C_SIZE;
									end else if (st_q.lenf) begin
										if (nx.decl == '0) begin
											nx.phase = PH_DONE;
											res.valid = 1'b1;
											res.finished = 1'b1;
											res.error_code = ERR_OK;
										end else begin
											nx.rem = nx.decl;
											nx.phase = PH_B_LEN;
										end
									end else begin
										nx.phase = PH_B_CLOSE;
									end
								end
							endcase
						end else if (st_q.cr) begin
							nx = line_char(nx, CH_CR);
							if (b != CH_CR) begin
								nx.cr = 1'b0;
								nx = line_char(nx, b);
							end
						end else if (b == CH_CR) begin
							nx.cr = 1'b1;
						end else begin
							nx = line_char(nx, b);
						end
					end
				endcase
			end
		end
	end

	assign adv = valid_s1 && (!out_ch.valid || out_ch.ready);
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clear_st();
			max_q <= MAX_BYTES_RST;
			out_ch.valid <= 1'b0;
		end else begin
			if (adv) st_q <= nx;
			if (cfg_ch.valid) max_q <= cfg_ch.data;
			if (adv) out_ch.valid <= res.valid;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			out_ch.body_byte <= res.body_byte;
			out_ch.has_body <= res.has_body;
			out_ch.finished <= res.finished;
			out_ch.error_code <= res.error_code;
		end
	end

`ifndef SYNTHESIS
	a_clear_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.func == FUNC_CLEAR |=> st_q.phase == PH_STATUS && st_q.rcv == '0)
		else $error("clear did not restart the parser");
	a_body_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.has_body |-> out_ch.error_code == ERR_OK)
		else $error("body byte carries an error");
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		adv && res.valid && res.finished |=> st_q.phase == PH_DONE)
		else $error("finished result without done phase");
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.func != FUNC_CLEAR |=> st_q.rcv >= $past(st_q.rcv))
		else $error("received count went backward");
`endif

endmodule

@@ sv/http_response_body_framer_top.sv @@
// Top level of the HTTP/1.1 response body framer.
// A result passes the input register, then the result register, after its item's transfer.
// Throughput: one item per cycle while the result register is not stalled; the only loop
// is the parser state update.
// Reset (arst_n low) returns the parser to the status line and the limit to 8 MiB.
// Depends on hfr_pkg, hfr_if, hfr_in_reg and hfr_step.
module http_response_body_framer_top #(
	parameter int unsigned LENGTH_BITS = hfr_pkg::LENGTH_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	hfr_in_if.sink   in_ch,
	hfr_out_if.source out_ch,
	hfr_cfg_if.sink  cfg_ch
);
	import hfr_pkg::*;

	// The input register frees itself whenever the step stage advances, so a new
	// transfer is taken in the same cycle that the held item is processed.
	logic  valid_s1;
	item_t item_s1;
	logic  adv;

	hfr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// The step stage holds all parser state and the result register; it advances
	// whenever its result register is empty or being drained.
	hfr_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.adv      (adv),
		.out_ch   (out_ch),
		.cfg_ch   (cfg_ch)
	);

endmodule

@@ tb/hfr_framer_checker.sv @@
// Checker for the HTTP response body framer: watches the input, result and
// configuration transfers, predicts each result and compares it field by field.
// Depends on hfr_pkg; it takes plain signals rather than the channel interfaces in hfr_if.
`timescale 1ns / 100ps

module hfr_framer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  in_func,
	input  logic [7:0]  in_data,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  out_body,
	input  logic        out_has,
	input  logic        out_fin,
	input  logic [2:0]  out_err,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import hfr_pkg::*;

	typedef enum logic [3:0] {
		P_STATUS, P_LEAD, P_NAME, P_TRAIL, P_VALUE, P_CSIZE, P_CDATA, P_CTAIL,
		P_BLEN, P_BCLOSE, P_DONE
	} parse_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       has_body;
		logic       finished;
		logic [2:0] error_code;
	} frame_res_t;

	frame_res_t expected_frames[$];

	logic [31:0] byte_limit;
	parse_t      ph;
	bit          cr_seen;
	int unsigned line_pos, name_idx, cands, tok_idx, scan_st;
	bit          neg, chunked, has_len;
	logic [31:0] decl_len, remaining, rx_count;

	assign pending = expected_frames.size();

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
	endfunction

	function automatic bit blank(logic [7:0] c);
		return c == " " || c == 8'h09;
	endfunction

	task automatic clear_line();
		line_pos = 0; name_idx = 0; cands = 3; tok_idx = 0; scan_st = 0; neg = 0;
	endtask

	task automatic clear_response();
		ph = P_STATUS; cr_seen = 0; clear_line();
		chunked = 0; has_len = 0; decl_len = 0; remaining = 0; rx_count = 0;
	endtask

	// Number scan in the manner of an unsigned C conversion, saturating at all ones.
	task automatic scan_digit(logic [7:0] c, bit hex, inout logic [31:0] acc);
		int unsigned base, d;
		logic [63:0] wide;
		base = hex ? 16 : 10;
		d = 16;
		if (c >= "0" && c <= "9") d = c - "0";
		else if (hex && c >= "a" && c <= "f") d = c - "a" + 10;
		else if (hex && c >= "A" && c <= "F") d = c - "A" + 10;
		if (scan_st == 0) begin
			if (blank(c) || (c >= 10 && c <= 13)) return;
			if (c == "+" || c == "-") begin
				if (c == "-") neg = 1;
				scan_st = 1;
				return;
			end
			scan_st = 1;
		end
		if (scan_st == 1) begin
			if (hex && c == "0") begin
				scan_st = 2;
				return;
			end
			scan_st = (d < base) ? 3 : 4;
		end else if (scan_st == 2) begin
			if (c == "x" || c == "X") begin
				scan_st = 3;
				return;
			end
			scan_st = (d < base) ? 3 : 4;
		end else if (scan_st == 3) begin
			if (d >= base) scan_st = 4;
		end else begin
			return;
		end
		if (scan_st == 3 && d < base) begin
			wide = 64'(acc) * base + d;
			acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
		end
	endtask

	task automatic feed_name(logic [7:0] lc);
		if ((cands & 1) && !(name_idx < 17 && lc == TOK_TE[16 - name_idx])) cands &= ~1;
		if ((cands & 2) && !(name_idx < 14 && lc == TOK_CL[13 - name_idx])) cands &= ~2;
		if (name_idx < 31) name_idx++;
	endtask

	task automatic start_value(bit named);
		int unsigned kind;
		kind = 0;
		if (named && (cands & 1) && name_idx == 17) kind = 1;
		else if (named && (cands & 2) && name_idx == 14) kind = 2;
		cands = kind;
		ph = P_VALUE;
		if (kind == 1) begin
			chunked = 0; tok_idx = 0;
		end
		if (kind == 2) begin
			has_len = 1; decl_len = 0; scan_st = 0; neg = 0;
		end
	endtask

	task automatic take_line_char(logic [7:0] c);
		logic [7:0] lc;
		lc = to_lower(c);
		if (line_pos < 31) line_pos++;
		case (ph)
			P_STATUS: begin
				if (tok_idx < 5) tok_idx = (c == TOK_HTTP[4 - tok_idx]) ? tok_idx + 1 : 6;
			end
			P_LEAD: begin
				if (c == ":") start_value(0);
				else if (!blank(c)) begin
					feed_name(lc);
					ph = P_NAME;
				end
			end
			P_NAME: begin
				if (c == ":") start_value(1);
				else if (blank(c)) ph = P_TRAIL;
				else feed_name(lc);
			end
			P_TRAIL: begin
				if (c == ":") start_value(1);
				else if (!blank(c)) begin
					cands = 0; feed_name(lc); ph = P_NAME;
				end
			end
			P_VALUE: begin
				if (cands == 1 && tok_idx < 7) begin
					if (lc == TOK_CHUNKED[6 - tok_idx]) tok_idx++;
					else tok_idx = (lc == "c") ? 1 : 0;
					if (tok_idx == 7) chunked = 1;
				end else if (cands == 2) begin
					scan_digit(c, 0, decl_len);
				end
			end
			P_CSIZE: scan_digit(c, 1, remaining);
			default: ;
		endcase
	endtask

	task automatic expect_frame(logic [7:0] b, bit has, bit fin, logic [2:0] err);
		expected_frames.push_back('{b, has, fin, err});
	endtask

	task automatic end_response(logic [2:0] err);
		ph = P_DONE; cr_seen = 0;
		expect_frame(8'd0, 0, 1, err);
	endtask

	task automatic take_line_end();
		case (ph)
			P_STATUS: begin
				if (tok_idx != 5) end_response(ERR_NOT_HTTP);
				else begin
					clear_line(); ph = P_LEAD;
				end
				return;
			end
			P_CSIZE: begin
				if (neg && remaining != 0) remaining = '1;
				clear_line();
				if (remaining == 0) end_response(ERR_OK);
				else ph = P_CDATA;
				return;
			end
			P_CTAIL: begin
				clear_line(); remaining = 0; ph = P_CSIZE;
				return;
			end
			default: ;
		endcase
		if (ph == P_VALUE && cands == 2 && neg && decl_len != 0) decl_len = '1;
		if (line_pos != 0) begin
			clear_line(); ph = P_LEAD;
			return;
		end
		clear_line();
		if (chunked) begin
			remaining = 0; ph = P_CSIZE;
		end else if (has_len) begin
			if (decl_len == 0) end_response(ERR_OK);
			else begin
				remaining = decl_len; ph = P_BLEN;
			end
		end else begin
			ph = P_BCLOSE;
		end
	endtask

	task automatic predict_item(logic [1:0] f, logic [7:0] b);
		if (f == FUNC_CLEAR) begin
			clear_response();
			return;
		end
		if (f != FUNC_BYTE && f != FUNC_CLOSE) return;
		if (ph == P_DONE) return;
		if (f == FUNC_CLOSE) begin
			if (rx_count > byte_limit) end_response(ERR_TOO_LARGE);
			else if (ph == P_BCLOSE) end_response(ERR_OK);
			else if (ph == P_CDATA || ph == P_BLEN) end_response(ERR_TRUNCATED);
			else end_response(ERR_MID_LINE);
			return;
		end
		if (rx_count > byte_limit) begin
			end_response(ERR_TOO_LARGE);
			return;
		end
		if (rx_count != '1) rx_count++;
		case (ph)
			P_CDATA: begin
				remaining--;
				if (remaining == 0) begin
					clear_line(); ph = P_CTAIL;
				end
				expect_frame(b, 1, 0, ERR_OK);
				return;
			end
			P_BLEN: begin
				remaining--;
				if (remaining == 0) ph = P_DONE;
				expect_frame(b, 1, remaining == 0, ERR_OK);
				return;
			end
			P_BCLOSE: begin
				expect_frame(b, 1, 0, ERR_OK);
				return;
			end
			default: ;
		endcase
		if (cr_seen) begin
			if (b == CH_LF) begin
				cr_seen = 0;
				take_line_end();
				return;
			end
			take_line_char(CH_CR);
			if (b != CH_CR) begin
				cr_seen = 0;
				take_line_char(b);
			end
			return;
		end
		if (b == CH_CR) cr_seen = 1;
		else take_line_char(b);
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: framer result %s is %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		byte_limit = MAX_BYTES_RST;
		clear_response();
	end

	always @(posedge clk) begin
		frame_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					$display("%0t: framer result with nothing expected", $time);
					fail_count++;
				end else begin
					want = expected_frames.pop_front();
					if (out_body != want.body_byte)
						report_mismatch("body_byte", out_body, want.body_byte);
					if (out_has != want.has_body)
						report_mismatch("has_body", out_has, want.has_body);
					if (out_fin != want.finished)
						report_mismatch("finished", out_fin, want.finished);
					if (out_err != want.error_code)
						report_mismatch("error_code", out_err, want.error_code);
				end
			end
			if (cfg_valid && cfg_ready) byte_limit = cfg_data;
			if (in_valid && in_ready) predict_item(in_func, in_data);
		end
	end
endmodule

@@ tb/http_response_body_framer_top_tb.sv @@
// Testbench top for the HTTP response body framer: drives responses, closes and
// clears, writes the byte limit, and gives the verdict. Depends on hfr_pkg,
// hfr_if, the framer RTL and hfr_framer_checker.
`timescale 1ns / 100ps

module http_response_body_framer_top_tb;
	import hfr_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   items_sent;

	hfr_in_if  in_ch ();
	hfr_out_if out_ch ();
	hfr_cfg_if cfg_ch ();

	http_response_body_framer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	hfr_framer_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_func    (in_ch.func),
		.in_data    (in_ch.data_byte),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_body   (out_ch.body_byte),
		.out_has    (out_ch.has_body),
		.out_fin    (out_ch.finished),
		.out_err    (out_ch.error_code),
		.cfg_valid  (cfg_ch.valid),
		.cfg_ready  (cfg_ch.ready),
		.cfg_data   (cfg_ch.data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// The receiver stalls at random; the rate is changed per phase of the run.
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Hard limit on the run; it is far above the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 200000) begin
			$display("FAIL http_response_body_framer_top");
			$finish;
		end
	end

	// One transfer on the input channel, with a random gap before it.
	// valid stays high across back-to-back items; whoever stops sending drops it.
	task automatic send_item(logic [1:0] f, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid     <= 1;
		in_ch.func      <= f;
		in_ch.data_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_item(FUNC_BYTE, s[i]);
	endtask

	// Waits until every predicted result has arrived, then lets the pipeline drain.
	task automatic drain();
		in_ch.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		drain();
		cfg_ch.valid <= 1;
		cfg_ch.data  <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 0;
	endtask

	function automatic string rand_case(string s);
		string r;
		r = s;
		for (int i = 0; i < r.len(); i++)
			if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1)) r[i] = r[i] - 8'd32;
		return r;
	endfunction

	function automatic string pad();
		return ($urandom_range(3) == 0) ? " \t" : ($urandom_range(1) ? " " : "");
	endfunction

	// One response built from a random recipe: mostly well formed, with random
	// body content, some broken framing, and random noise bytes.
	task automatic send_response();
		int    mode, n, chunks;
		string hdr;
		send_item(FUNC_CLEAR, 8'($urandom));
		if ($urandom_range(9) == 0) send_text("HTTX/1.1 200\r\n");
		else send_text("HTTP/1.1 200 OK\r\n");
		mode = $urandom_range(3);
		n = $urandom_range(12);
		if ($urandom_range(4) == 0) send_text("X-Junk no colon here\r\n");
		if ($urandom_range(3) == 0) send_text("Content-Type: text/plain\r\n");
		case (mode)
			0: begin
				hdr = {pad(), rand_case("transfer-encoding"), pad(), ":", pad(),
					$urandom_range(3) == 0 ? "gzip, chunked" : "chunked", "\r\n"};
				send_text(hdr);
				if ($urandom_range(4) == 0) send_text(rand_case("Content-Length: 5\r\n"));
			end
			1: begin
				hdr = $sformatf("%s:%s%0d\r\n", rand_case("content-length"), pad(), n);
				send_text(hdr);
			end
			2: ;
			default: begin
				send_text($sformatf("content-length: -%0d\r\n", n));
				send_text("transfer-encoding: identity\r\n");
			end
		endcase
		send_text("\r\n");
		if (mode == 0) begin
			chunks = $urandom_range(3);
			for (int c = 0; c < chunks; c++) begin
				n = $urandom_range(1, 6);
				case ($urandom_range(2))
					0: send_text($sformatf("%0h\r\n", n));
					1: send_text($sformatf("0x%0H;ext=1\r\n", n));
					default: send_text($sformatf(" %0h \r\n", n));
				endcase
				for (int k = 0; k < n; k++) send_item(FUNC_BYTE, 8'($urandom));
				send_text($urandom_range(5) == 0 ? "junk\r\n" : "\r\n");
			end
			if ($urandom_range(4) != 0) send_text("0\r\n\r\n");
		end else begin
			n = $urandom_range(14);
			for (int k = 0; k < n; k++) send_item(FUNC_BYTE, 8'($urandom));
		end
		if ($urandom_range(5) == 0)
			repeat ($urandom_range(1, 5)) send_item(FUNC_BYTE, 8'($urandom));
		if ($urandom_range(1)) send_item(FUNC_CLOSE, 8'($urandom));
		if ($urandom_range(7) == 0) send_item(FUNC_UNUSED, 8'($urandom));
	endtask

	initial begin
		arst_n          = 0;
		cycle_count     = 0;
		items_sent      = 0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		in_ch.valid     = 0;
		in_ch.func      = FUNC_BYTE;
		in_ch.data_byte = 0;
		out_ch.ready    = 1;
		cfg_ch.valid    = 0;
		cfg_ch.data     = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed part: every framing rule, each error but too large, field extremes, the unused code.
		send_text("HTTP/1.1 200 OK\r\nContent-Length: 3\r\n\r\n");
		send_item(FUNC_BYTE, 8'h00); send_item(FUNC_BYTE, 8'hFF); send_item(FUNC_BYTE, 8'hA5);
		send_item(FUNC_CLEAR, 8'hFF);
		send_text("http/1.1\r\n");
		send_item(FUNC_CLEAR, 0);
		send_text("HTTP/1.0 200\r\nHdr\r");
		send_item(FUNC_CLOSE, 8'hFF);
		send_item(FUNC_UNUSED, 8'h5A);
		send_item(FUNC_CLEAR, 0);
		send_text("HTTP/1.1 200\r\n TRANSFER-ENCODING :x chunked\r\n\r\n0X3;a\r\nabc\r\n0\r\n");
		send_item(FUNC_CLEAR, 0);
		send_text("HTTP/1.1 200\r\nContent-Length: 99999999999\r\n\r\nab");
		send_item(FUNC_CLOSE, 0);
		send_item(FUNC_CLEAR, 0);
		send_text("HTTP/1.1 200\r\n\r\nxy");
		send_item(FUNC_CLOSE, 0);
		send_item(FUNC_BYTE, 8'h41);

		// Tight limits: zero, then one, then no limit at all.
		write_limit(32'd0);
		send_item(FUNC_CLEAR, 0);
		send_text("HTT");
		write_limit(32'd1);
		send_item(FUNC_CLEAR, 0);
		send_text("HTTP");
		send_item(FUNC_CLOSE, 0);
		write_limit(32'hFFFF_FFFF);

		// Random part in three pressure phases.
		for (int phase_no = 0; phase_no < 3; phase_no++) begin
			send_idle_pct = (phase_no == 0) ? 35 : (phase_no == 1) ? 50 : 0;
			recv_idle_pct = (phase_no == 0) ? 50 : (phase_no == 1) ? 35 : 0;
			if (phase_no == 1) write_limit(32'd40);
			if (phase_no == 2) write_limit(MAX_BYTES_RST);
			while (items_sent < 220 + (phase_no + 1) * 140) begin
				send_response();
				// Now and then the sender holds off until all results are in.
				if ($urandom_range(7) == 0) begin
					in_ch.valid <= 0;
					@(negedge clk);
					while (pending != 0) @(negedge clk);
				end
			end
		end

		drain();
		if (fail_count == 0) begin
			$display("PASS http_response_body_framer_top");
		end else begin
			$display("FAIL http_response_body_framer_top");
		end
		$finish;
	end
endmodule
